FILE: rtl/mire_pkg.sv
// package for the median interval rate estimator
// shared widths, status codes and state encoding; no dependencies
package mire_pkg;

  localparam int unsigned MaxSamplesDef = 256;
  localparam int unsigned TicksPerSecDef = 1000000;

  localparam int unsigned TimeW = 48;
  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 49;
  localparam int unsigned RateW = 36;
  localparam int unsigned BitW  = 6;

  localparam logic [RateW-1:0] RateMax = '1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_BAD = 2'd2,
    ST_OVF = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DECIDE,
    S_SEL1,
    S_SEL2,
    S_DIV,
    S_FIN
  } state_e;

endpackage

FILE: rtl/median_interval_rate_estimator.sv
// top level of the median interval rate estimator
// depends on mire_pkg, mire_sel and mire_div
//
// Input channel: one timestamp per beat (sample_time_i, is_last_i), taken at one
// beat per cycle while a segment loads. The beat carrying is_last_i closes the
// segment and causes one result beat (rate_q16_o, status_o); no other beat does.
// After the closing beat in_ready_o stays low until the result is in the output
// register. With fewer than two samples or a bad interval the state goes from
// S_DECIDE straight to S_FIN; with two or three samples the divider alone sets
// it. Otherwise the median is found by radix selection over the interval
// memory: 48 passes over the m inner intervals, done twice for an even m, then
// the divider. Loading of the next segment may start while a result still
// waits for out_ready_i; a stalled result holds its value and the result of a
// further closing beat waits in S_FIN. Reset clears all control state and the
// sample count; the interval memory needs no clearing.
module median_interval_rate_estimator import mire_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned TICKS_PER_SECOND = TicksPerSecDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TimeW-1:0] sample_time_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RateW-1:0] rate_q16_o,
  output logic [1:0]       status_o
);

  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AddrW = $clog2(MAX_SAMPLES);
  localparam logic [NumW-1:0] Scale = NumW'(TICKS_PER_SECOND) << 16;

  state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, n_q;
  logic [TimeW-1:0] first_q, prev_q, a_q;
  logic             ovf_q, bad_q, seg_ovf_q, seg_bad_q;
  logic             out_valid_q;
  logic [RateW-1:0] out_rate_q, res_rate_q;
  status_e          out_stat_q, res_stat_q;

  logic             in_acc, full, wr_en;
  logic [CntW-1:0]  m, rank1, sel_rank;
  logic             sel_start, sel_done, div_start, div_done;
  logic [TimeW-1:0] sel_value;
  logic [RateW-1:0] quot;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic             out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign full     = cnt_q >= CntW'(MAX_SAMPLES);
  assign wr_en    = in_acc && !full && cnt_q != '0;
  assign m        = n_q - CntW'(3);
  assign rank1    = (m - CntW'(1)) >> 1;
  assign out_free = !out_valid_q || out_ready_i;

  mire_sel #(.MaxSamples(MAX_SAMPLES)) u_sel (
    .clk_i,
    .rst_ni,
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrW'(cnt_q - CntW'(1))),
    .wr_data_i (sample_time_i - prev_q),
    .start_i   (sel_start),
    .m_i       (m),
    .rank_i    (sel_rank),
    .done_o    (sel_done),
    .value_o   (sel_value)
  );

  mire_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:   if (in_acc && is_last_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (n_q < CntW'(2) || seg_bad_q) state_d = S_FIN;
        else if (n_q < CntW'(4))         state_d = S_DIV;
        else                             state_d = S_SEL1;
      end
      S_SEL1:   if (sel_done) state_d = m[0] ? S_DIV : S_SEL2;
      S_SEL2:   if (sel_done) state_d = S_DIV;
      S_DIV:    if (div_done) state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_LOAD;
      default:  state_d = S_LOAD;
    endcase
  end

  // unit starts and operands
  always_comb begin
    in_ready_o = state_q == S_LOAD;
    sel_start  = 1'b0;
    sel_rank   = rank1;
    div_start  = 1'b0;
    div_num    = Scale;
    div_den    = {1'b0, sel_value};
    case (state_q)
      S_DECIDE: begin
        if (n_q >= CntW'(2) && !seg_bad_q) begin
          if (n_q < CntW'(4)) begin
            div_start = 1'b1;
            div_num   = (n_q == CntW'(3)) ? Scale << 1 : Scale;
            div_den   = {1'b0, prev_q - first_q};
          end else begin
            sel_start = 1'b1;
          end
        end
      end
      S_SEL1: begin
        if (sel_done) begin
          if (m[0]) begin
            div_start = 1'b1;
          end else begin
            sel_start = 1'b1;
            sel_rank  = rank1 + CntW'(1);
          end
        end
      end
      S_SEL2: begin
        if (sel_done) begin
          div_start = 1'b1;
          div_num   = Scale << 1;
          div_den   = {1'b0, a_q} + {1'b0, sel_value};
        end
      end
      default: ;
    endcase
  end

  // state and segment control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (is_last_i) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          bad_q <= 1'b0;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q != '0 && sample_time_i <= prev_q) bad_q <= 1'b1;
        end
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // timestamps, segment snapshot and results
  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      if (cnt_q == '0) first_q <= sample_time_i;
      prev_q <= sample_time_i;
    end
    if (in_acc && is_last_i) begin
      n_q       <= full ? cnt_q : cnt_q + CntW'(1);
      seg_ovf_q <= ovf_q || full;
      seg_bad_q <= bad_q || (!full && cnt_q != '0 && sample_time_i <= prev_q);
    end
    if (state_q == S_SEL1 && sel_done) a_q <= sel_value;
    if (state_q == S_DECIDE) begin
      res_rate_q <= '0;
      res_stat_q <= (n_q < CntW'(2)) ? ST_FEW : ST_BAD;
    end
    if (state_q == S_DIV && div_done) begin
      res_rate_q <= quot;
      res_stat_q <= seg_ovf_q ? ST_OVF : ST_OK;
    end
    if (state_q == S_FIN && out_free) begin
      out_rate_q <= res_rate_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_q16_o  = out_rate_q;
  assign status_o    = out_stat_q;

endmodule

FILE: rtl/mire_sel.sv
// interval memory and radix selection of the k-th smallest entry
// depends on mire_pkg; one bit of the result is settled per pass over entries 1..m
module mire_sel import mire_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDef,
  localparam int unsigned CntW = $clog2(MaxSamples + 1),
  localparam int unsigned AddrW = $clog2(MaxSamples)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [TimeW-1:0] wr_data_i,
  input  logic             start_i,
  input  logic [CntW-1:0]  m_i,
  input  logic [CntW-1:0]  rank_i,
  output logic             done_o,
  output logic [TimeW-1:0] value_o
);

  logic [TimeW-1:0] mem [MaxSamples];
  logic [TimeW-1:0] rdata_q;

  logic             busy_q, issue_q, rvalid_q, rlast_q, done_q;
  logic [AddrW-1:0] addr_q, m_q;
  logic [BitW-1:0]  bit_q;
  logic [CntW-1:0]  cnt_q, rank_q;
  logic [TimeW-1:0] prefix_q;

  logic [TimeW-1:0] low_mask, hi_mask;
  logic             match;
  logic [CntW-1:0]  cnt_n;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue_q) begin
      rdata_q <= mem[addr_q];
    end
  end

  // does the entry share the prefix above the current bit and hold a zero there
  always_comb begin
    low_mask = TimeW'(1) << bit_q;
    hi_mask  = ~(low_mask | (low_mask - TimeW'(1)));
    match    = (((rdata_q ^ prefix_q) & hi_mask) == '0) && !rdata_q[bit_q];
    cnt_n    = cnt_q + CntW'(match);
  end

  // pass sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      issue_q  <= 1'b0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        issue_q  <= 1'b1;
        rvalid_q <= 1'b0;
      end else if (busy_q) begin
        rvalid_q <= issue_q;
        rlast_q  <= addr_q == m_q;
        if (issue_q && addr_q == m_q) begin
          issue_q <= 1'b0;
        end
        if (rvalid_q && rlast_q) begin
          if (bit_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            issue_q <= 1'b1;
          end
        end
      end
    end
  end

  // payload of the sequencer
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addr_q   <= AddrW'(1);
      m_q      <= m_i[AddrW-1:0];
      bit_q    <= BitW'(TimeW - 1);
      cnt_q    <= '0;
      rank_q   <= rank_i;
      prefix_q <= '0;
    end else if (busy_q) begin
      if (issue_q && addr_q != m_q) begin
        addr_q <= addr_q + AddrW'(1);
      end
      if (rvalid_q) begin
        if (rlast_q) begin
          if (rank_q >= cnt_n) begin
            prefix_q[bit_q] <= 1'b1;
            rank_q          <= rank_q - cnt_n;
          end
          cnt_q  <= '0;
          addr_q <= AddrW'(1);
          if (bit_q != '0) begin
            bit_q <= bit_q - BitW'(1);
          end
        end else begin
          cnt_q <= cnt_n;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = prefix_q;

endmodule

FILE: rtl/mire_div.sv
// restoring divider with saturation to the rate width
// depends on mire_pkg; one quotient bit per cycle
module mire_div import mire_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  output logic             done_o,
  output logic [RateW-1:0] quot_o
);

  logic            busy_q, done_q;
  logic [BitW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   rem_sh, diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    diff   = rem_sh - {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= BitW'(NumW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - BitW'(1);
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_q <= diff[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = (quo_q > NumW'(RateMax)) ? RateMax : quo_q[RateW-1:0];

endmodule

FILE: rtl/mire_checker.sv
// port-level checks for the median interval rate estimator
// depends on mire_pkg; bound to the top level below
module mire_checker import mire_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [RateW-1:0] rate_q16_o,
  input logic [1:0]       status_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rate_q16_o) && $stable(status_o))
    else $error("stalled result changed");

  // error results carry a zero rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FEW || status_o == ST_BAD) |-> rate_q16_o == '0)
    else $error("error result with nonzero rate");

  // a new result only appears after the input was held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without closing beat");

endmodule

bind median_interval_rate_estimator mire_checker u_mire_checker (
  .clk_i,
  .rst_ni,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .rate_q16_o,
  .status_o
);
